// ===== rtl/core/mols_pkg.sv =====
package mols_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] median;
		logic [COUNT_W-1:0]       count;
		logic                     overflow;
	} result_t;

	typedef enum logic [1:0] {
		SEL_IDLE,
		SEL_CAND_RD,
		SEL_CAND_LD,
		SEL_SCAN
	} sel_state_t;

endpackage

// ===== rtl/core/mols_ram.sv =====
module mols_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/mols_select.sv =====
module mols_select
	import mols_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]     n,
	input  logic                               ovf,
	output logic                               busy,
	output logic [$clog2(MAX_ITEMS)-1:0]       rd_addr,
	input  logic signed [DATA_W-1:0]           rd_data,
	output logic                               done,
	output result_t                            result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	sel_state_t               state_q, state_d;
	logic [AW-1:0]            i_q;
	logic [CW-1:0]            j_q;
	logic [AW-1:0]            j_s1;
	logic [CW-1:0]            rank_q;
	logic signed [DATA_W-1:0] cand_q;
	logic [CW-1:0]            n_q;
	logic [CW-1:0]            k_q;
	logic                     ovf_q;
	logic                     done_q;
	result_t                  result_q;

	logic          below;
	logic [CW-1:0] rank_nxt;
	logic          last_j;
	logic          hit;

	// Rank of the candidate: elements strictly below it, plus equal ones at a lower index.
	assign below    = (rd_data < cand_q) || ((rd_data == cand_q) && (j_s1 < i_q));
	assign rank_nxt = rank_q + CW'(below);
	assign last_j   = ((CW'(j_s1) + CW'(1)) == n_q);
	assign hit      = (state_q == SEL_SCAN) && last_j && (rank_nxt == k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		case (state_q)
			SEL_IDLE: begin
				if (go) begin
					state_d = SEL_CAND_RD;
				end
			end
			SEL_CAND_RD: begin
				rd_addr = i_q;
				state_d = SEL_CAND_LD;
			end
			SEL_CAND_LD: begin
				state_d = SEL_SCAN;
			end
			SEL_SCAN: begin
				rd_addr = (j_q < n_q) ? j_q[AW-1:0] : '0;
				if (last_j) begin
					state_d = hit ? SEL_IDLE : SEL_CAND_RD;
				end
			end
			default: begin
				state_d = SEL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEL_IDLE: begin
				if (go) begin
					n_q   <= n;
					k_q   <= n >> 1;
					ovf_q <= ovf;
					i_q   <= '0;
				end
			end
			SEL_CAND_LD: begin
				cand_q <= rd_data;
				j_s1   <= '0;
				j_q    <= CW'(1);
				rank_q <= '0;
			end
			SEL_SCAN: begin
				rank_q <= rank_nxt;
				j_s1   <= j_q[AW-1:0];
				j_q    <= j_q + CW'(1);
				if (hit) begin
					result_q.median   <= cand_q;
					result_q.count    <= COUNT_W'(n_q);
					result_q.overflow <= ovf_q;
				end else if (last_j) begin
					// advance to the next candidate
					i_q <= i_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hit;
		end
	end

	assign busy   = (state_q != SEL_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == SEL_SCAN))
		else $error("result beat without a finished scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEL_SCAN) |-> (CW'(j_s1) < n_q))
		else $error("scan index beyond set size");

	a_cand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEL_CAND_RD) |-> (CW'(i_q) < n_q))
		else $error("no candidate held the median rank");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEL_SCAN) |-> (rank_q <= CW'(j_s1)))
		else $error("rank count ran ahead of scan");

endmodule

// ===== rtl/core/median_of_loaded_set_core.sv =====
// Median of a loaded set. Each accepted beat (start high while busy is low) stores one
// signed value into the element RAM; busy stays low while a set loads. Values beyond
// MAX_ITEMS are dropped and flagged. The beat with last set closes the set and raises
// busy while the median is selected: for each candidate position the single read port
// of the element RAM walks the whole set of n kept values to compute the candidate's
// rank, so each candidate tried costs a read and a load of the candidate and a scan of
// all n values. The result (upper median for an even count) appears on result with done
// high for exactly one cycle and cannot be stalled; busy drops in that same cycle, so
// the next set may start at once. No clearing pass follows reset.
module median_of_loaded_set_core
	import mols_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0]     fill_q;
	logic              dropped_q;
	logic              accept;
	logic              full;
	logic              go;
	logic [CW-1:0]     set_n;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	assign accept = start && !busy;
	assign full   = (fill_q == CW'(MAX_ITEMS));
	assign go     = accept && item.last;
	assign set_n  = full ? fill_q : (fill_q + CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end else if (full) begin
				dropped_q <= 1'b1;
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	mols_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (accept && !full),
		.waddr(fill_q[AW-1:0]),
		.wdata(item.value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	mols_select #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.n      (set_n),
		.ovf    (dropped_q || full),
		.busy   (busy),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.done   (done),
		.result (result)
	);

endmodule

// ===== tb/sv/median_checker.sv =====
module median_checker
	import mols_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      checked
);

	// kept values of the set being loaded, held in ascending signed order
	logic signed [DATA_W-1:0] kept_sorted[$];
	logic                     set_dropped;
	result_t                  medians_due[$];

	int fails = 0;
	int due_count = 0;
	int compared = 0;

	assign fail_count = fails;
	assign pending    = due_count;
	assign checked    = compared;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fails++;
	endtask

	task automatic load_element(input item_t beat);
		int      pos;
		result_t due;
		if (kept_sorted.size() < MAX_ITEMS) begin
			pos = 0;
			while (pos < kept_sorted.size() && kept_sorted[pos] <= $signed(beat.value))
				pos++;
			kept_sorted.insert(pos, $signed(beat.value));
		end else begin
			set_dropped = 1'b1;
		end
		if (beat.last) begin
			due.median   = kept_sorted[kept_sorted.size() / 2];
			due.count    = COUNT_W'(kept_sorted.size());
			due.overflow = set_dropped;
			medians_due.push_back(due);
			kept_sorted.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (medians_due.size() == 0) begin
			report_mismatch($sformatf("result with nothing due: median=%0d count=%0d overflow=%0b",
				$signed(got.median), got.count, got.overflow));
			return;
		end
		want = medians_due.pop_front();
		compared++;
		if (got.median !== want.median)
			report_mismatch($sformatf("median: got %0d, want %0d",
				$signed(got.median), $signed(want.median)));
		if (got.count !== want.count)
			report_mismatch($sformatf("count: got %0d, want %0d", got.count, want.count));
		if (got.overflow !== want.overflow)
			report_mismatch($sformatf("overflow: got %0b, want %0b", got.overflow, want.overflow));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_sorted.delete();
			medians_due.delete();
			set_dropped = 1'b0;
			due_count = 0;
		end else begin
			// a result and a new beat can share an edge: the result belongs to an older set
			if (done)
				check_result(result);
			if (start && !busy)
				load_element(item);
			due_count = medians_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import mols_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 400;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    done;
	result_t result;

	int fail_count;
	int pending;
	int checked;

	int idle_cycles = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	int items_sent = 0;
	int sets_sent = 0;
	int largest_set = 0;
	int overflow_sets = 0;
	logic signed [DATA_W-1:0] recent_value = '0;

	always #10 clk = ~clk;

	median_of_loaded_set_core #(
		.MAX_ITEMS(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	median_checker #(
		.MAX_ITEMS(CAPACITY)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] draw_element();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = 32'sh7FFF_FFFF;
			1:       v = 32'sh8000_0000;
			2, 3:    v = int'($urandom_range(0, 20)) - 10;
			4:       v = recent_value;
			default: v = $urandom;
		endcase
		recent_value = v;
		return v;
	endfunction

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!steady && $urandom_range(0, 2) != 0)
				hold_off($urandom_range(1, 6));
		end
		burst_left--;
		start <= 1'b1;
		item  <= {v, lst};
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		items_sent++;
		if (lst)
			sets_sent++;
	endtask

	task automatic send_set(input int len);
		for (int k = 0; k < len; k++)
			send_item(draw_element(), k == len - 1);
		if (len > largest_set)
			largest_set = len;
		if (len > CAPACITY)
			overflow_sets++;
	endtask

	// hold the sender until every due median is out
	task automatic drain_results();
		start <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		int len;
		int rand_sets;
		int pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-element sets at the extremes
		send_item(32'sh7FFF_FFFF, 1'b1);
		send_item(32'sh8000_0000, 1'b1);
		send_item(32'sh0000_0000, 1'b1);
		send_item(-32'sd1, 1'b1);
		// even count picks the upper of the two middle values
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7FFF_FFFF, 1'b1);
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh0000_0000, 1'b0);
		send_item(-32'sd1, 1'b1);
		// repeated values
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b1);
		// descending arrival
		send_item(32'sd3, 1'b0);
		send_item(32'sd2, 1'b0);
		send_item(32'sd1, 1'b1);
		largest_set = 4;
		drain_results();

		rand_sets = 0;
		while (items_sent < RANDOM_ITEMS || sets_sent < 24) begin
			steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (rand_sets == 0)
				len = CAPACITY;
			else if (rand_sets == 1)
				len = CAPACITY + 2;
			else if (pick < 80)
				len = $urandom_range(1, 8);
			else if (pick < 92)
				len = $urandom_range(9, 24);
			else if (pick < 96)
				len = CAPACITY;
			else
				len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
			send_set(len);
			rand_sets++;
			if (rand_sets == 20 || $urandom_range(0, 9) == 0)
				drain_results();
		end

		drain_results();
		repeat (100) @(posedge clk);

		$display("Loaded %0d values in %0d sets; largest set %0d, %0d sets ran past capacity.",
			items_sent, sets_sent, largest_set, overflow_sets);
		$display("Compared %0d medians field by field.", checked);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mols_pkg.sv
rtl/core/mols_ram.sv
rtl/core/mols_select.sv
rtl/core/median_of_loaded_set_core.sv
tb/sv/median_checker.sv
tb/sv/testbench.sv
